// ===== rtl/core/pvrtsd_pkg.sv =====
`default_nettype none

package pvrtsd_pkg;

    // Fixed widths of the file interface.
    localparam int POS_W = 27;
    localparam int LVL_W = 4;

    // Defaults for the top-level parameters.
    localparam int MAX_DIMENSION_DEF     = 8192;
    localparam int MAX_DECODED_BYTES_DEF = 134217728;

    // Register byte addresses.
    localparam logic [1:0] REG_FILE_LENGTH = 2'd0;

    // Header constants.
    localparam logic [31:0] PVR_MAGIC    = 32'h0352_5650;
    localparam logic [63:0] FMT_RGB565   = 64'h0005_0605_0062_6772;
    localparam logic [63:0] FMT_RGBA4444 = 64'h0404_0404_6162_6772;
    localparam logic [63:0] FMT_RGB888   = 64'h0008_0808_0062_6772;
    localparam logic [POS_W:0] HEADER_BYTES = 28'd52;

    // Byte positions at which a header field is complete.
    localparam logic [POS_W-1:0] POS_MAGIC   = 27'd3;
    localparam logic [POS_W-1:0] POS_FLAGS   = 27'd7;
    localparam logic [POS_W-1:0] POS_FORMAT  = 27'd15;
    localparam logic [POS_W-1:0] POS_CSPACE  = 27'd19;
    localparam logic [POS_W-1:0] POS_CHANNEL = 27'd23;
    localparam logic [POS_W-1:0] POS_DIMS    = 27'd31;
    localparam logic [POS_W-1:0] POS_DEPTH   = 27'd35;
    localparam logic [POS_W-1:0] POS_SURF    = 27'd39;
    localparam logic [POS_W-1:0] POS_FACES   = 27'd43;
    localparam logic [POS_W-1:0] POS_MIPS    = 27'd47;
    localparam logic [POS_W-1:0] POS_META    = 27'd51;

    // Pixel format codes.
    localparam logic [1:0] PF_RGB565   = 2'd0;
    localparam logic [1:0] PF_RGBA4444 = 2'd1;
    localparam logic [1:0] PF_RGB888   = 2'd2;

    // Error codes.
    localparam logic [3:0] E_MAGIC     = 4'd0;
    localparam logic [3:0] E_FLAGS     = 4'd1;
    localparam logic [3:0] E_FORMAT    = 4'd2;
    localparam logic [3:0] E_CSPACE    = 4'd3;
    localparam logic [3:0] E_CHANNEL   = 4'd4;
    localparam logic [3:0] E_DIMS      = 4'd5;
    localparam logic [3:0] E_NOT2D     = 4'd6;
    localparam logic [3:0] E_MIPS      = 4'd7;
    localparam logic [3:0] E_META      = 4'd8;
    localparam logic [3:0] E_BUDGET    = 4'd9;
    localparam logic [3:0] E_SIZE      = 4'd10;
    localparam logic [3:0] E_TRUNCATED = 4'd11;

    // Result kinds.
    localparam logic RK_PIXEL = 1'b0;
    localparam logic RK_ERROR = 1'b1;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_PAYLOAD,
        ST_DONE
    } t_stage;

    typedef enum logic {
        S_RUN,
        S_SUM
    } t_ctrl_state;

    typedef struct packed {
        logic accept;
        logic sum_start;
        logic sum_step;
    } t_cmd;

    typedef struct packed {
        logic out_blocked;
        logic sum_req;
        logic sum_done;
    } t_status;

    // Rounded channel expansions (v*255 + m/2)/m: exp5 and exp6 by reciprocal
    // multiplication, exp4 by repeating the nibble; the results agree with the
    // rounded quotient over the whole input range.
    function automatic logic [7:0] exp5(input logic [4:0] v);
        logic [15:0] t;
        t = 16'(v) * 16'd527 + 16'd23;
        return t[13:6];
    endfunction

    function automatic logic [7:0] exp6(input logic [5:0] v);
        logic [15:0] t;
        t = 16'(v) * 16'd259 + 16'd33;
        return t[13:6];
    endfunction

    function automatic logic [7:0] exp4(input logic [3:0] v);
        return {v, v};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pvrtsd_ctrl.sv =====
`default_nettype none

module pvrtsd_ctrl
    import pvrtsd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        ready           = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.sum_start = 1'b0;
        o_cmd.sum_step  = 1'b0;
        case (r_state)
            S_RUN: begin
                ready           = !i_status.out_blocked;
                o_cmd.accept    = i_valid && ready;
                o_cmd.sum_start = o_cmd.accept && i_status.sum_req;
                if (o_cmd.sum_start) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_done) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    assign o_stall = !ready;

    // No word is taken while the level sum runs.
    a_no_accept_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SUM |-> !o_cmd.accept && o_stall)
        else $error("word accepted during level sum");

endmodule

`default_nettype wire

// ===== rtl/core/pvrtsd_dp.sv =====
`default_nettype none

module pvrtsd_dp
    import pvrtsd_pkg::*;
#(
    parameter int MAX_DIMENSION     = MAX_DIMENSION_DEF,
    parameter int MAX_DECODED_BYTES = MAX_DECODED_BYTES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire              i_cfg_we,
    input  wire [POS_W-1:0]  i_cfg_data,
    output logic [POS_W-1:0] o_file_length,
    input  wire [7:0]        i_data_byte,
    output logic             o_valid,
    input  wire              i_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [LVL_W-1:0] o_mip_level,
    output logic [3:0]       o_error_code,
    output logic             o_last
);

    localparam int DW = $clog2(MAX_DIMENSION + 1);
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;
    localparam int CW = (SW + 3 > POS_W + 1) ? SW + 3 : POS_W + 1;

    // File state.
    logic [POS_W-1:0] r_len;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [63:0]      r_shift, n_shift;
    logic [1:0]       r_fmt,   n_fmt;
    logic [DW-1:0]    r_bw,    n_bw;
    logic [DW-1:0]    r_bh,    n_bh;
    logic [LVL_W-1:0] r_lc,    n_lc;
    logic [DW-1:0]    r_lw,    n_lw;
    logic [DW-1:0]    r_lh,    n_lh;
    logic [LVL_W-1:0] r_cur,   n_cur;
    logic [PW-1:0]    r_left,  n_left;
    logic [15:0]      r_part,  n_part;
    logic [1:0]       r_bip,   n_bip;
    logic             r_failed, n_failed;
    t_stage           r_stage, n_stage;
    logic             r_shape_bad, n_shape_bad;

    // Registered pixel-count products, computed ahead of use.
    logic [PW-1:0]    r_base_pix;
    logic [PW-1:0]    r_next_pix;

    // Level sum unit.
    logic [DW-1:0]    r_sw;
    logic [DW-1:0]    r_sh;
    logic [LVL_W-1:0] r_sidx;
    logic [PW-1:0]    r_prod;
    logic             r_pv;
    logic [SW-1:0]    r_acc;

    // Output register.
    logic             r_out_valid;
    logic             r_kind;
    logic [7:0]       r_red, r_green, r_blue, r_alpha;
    logic [LVL_W-1:0] r_mip;
    logic [3:0]       r_code;
    logic             r_last;

    // Per-word combinational results.
    logic             emit;
    logic             e_kind;
    logic [7:0]       e_red, e_green, e_blue, e_alpha;
    logic [3:0]       e_code;
    logic             e_last;
    logic [63:0]      sh_new;
    logic [31:0]      hi, lo;
    logic [DW-1:0]    mx;
    logic [4:0]       maxl;
    logic [CW-1:0]    payload_bytes;
    logic [POS_W:0]   p1;
    logic [POS_W:0]   rsz;
    logic [POS_W:0]   need;
    logic [15:0]      v;
    logic             hdr_err;
    logic [3:0]       hdr_code;
    logic             sum_req;

    function automatic logic [DW-1:0] half_dim(input logic [DW-1:0] d);
        return (d > DW'(1)) ? (d >> 1) : DW'(1);
    endfunction

    assign sh_new = {i_data_byte, r_shift[63:8]};
    assign hi     = sh_new[63:32];
    assign lo     = sh_new[31:0];
    assign p1     = {1'b0, r_pos} + 1'b1;
    assign v      = {i_data_byte, r_part[7:0]};

    // Number of mip levels the larger base dimension allows.
    always_comb begin
        mx   = (r_bw > r_bh) ? r_bw : r_bh;
        maxl = 5'd1;
        for (int i = 1; i < DW; i++) begin
            if (mx[i]) begin
                maxl = 5'(i + 1);
            end
        end
    end

    assign payload_bytes = (r_fmt == PF_RGB888)
        ? CW'(r_acc) + (CW'(r_acc) << 1) : (CW'(r_acc) << 1);

    // Header field checks at the last byte of each field.
    always_comb begin
        hdr_err  = 1'b0;
        hdr_code = E_MAGIC;
        case (r_pos)
            POS_MAGIC: begin
                hdr_err  = (hi != PVR_MAGIC);
                hdr_code = E_MAGIC;
            end
            POS_FLAGS: begin
                hdr_err  = (hi != 32'd0);
                hdr_code = E_FLAGS;
            end
            POS_FORMAT: begin
                hdr_err  = (sh_new != FMT_RGB565) && (sh_new != FMT_RGBA4444)
                        && (sh_new != FMT_RGB888);
                hdr_code = E_FORMAT;
            end
            POS_CSPACE: begin
                hdr_err  = (hi != 32'd0);
                hdr_code = E_CSPACE;
            end
            POS_CHANNEL: begin
                hdr_err  = (hi != 32'd0);
                hdr_code = E_CHANNEL;
            end
            POS_DIMS: begin
                hdr_err  = (lo == 32'd0) || (hi == 32'd0)
                        || (lo > 32'(MAX_DIMENSION)) || (hi > 32'(MAX_DIMENSION));
                hdr_code = E_DIMS;
            end
            POS_FACES: begin
                hdr_err  = (hi != 32'd1) || r_shape_bad;
                hdr_code = E_NOT2D;
            end
            POS_MIPS: begin
                hdr_err  = (hi == 32'd0) || (hi > 32'(maxl));
                hdr_code = E_MIPS;
            end
            POS_META: begin
                if (hi != 32'd0) begin
                    hdr_err  = 1'b1;
                    hdr_code = E_META;
                end else if ((64'(r_acc) << 2) > 64'(MAX_DECODED_BYTES)) begin
                    hdr_err  = 1'b1;
                    hdr_code = E_BUDGET;
                end else if (payload_bytes + CW'(HEADER_BYTES) != CW'(r_len)) begin
                    hdr_err  = 1'b1;
                    hdr_code = E_SIZE;
                end
            end
            default: begin
                hdr_err = 1'b0;
            end
        endcase
    end

    // Size of the header read that starts at the next byte.
    always_comb begin
        if (p1 == 28'd8) begin
            rsz = 28'd8;
        end else if (p1 < HEADER_BYTES && p1[1:0] == 2'b00 && p1 != 28'd12) begin
            rsz = 28'd4;
        end else begin
            rsz = '0;
        end
    end

    assign sum_req = !r_failed && r_stage == ST_HEADER && r_pos == POS_MIPS
                  && !hdr_err && !(p1 + 28'd4 > {1'b0, r_len});

    // Per-word next state and result.
    always_comb begin
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_fmt       = r_fmt;
        n_bw        = r_bw;
        n_bh        = r_bh;
        n_lc        = r_lc;
        n_lw        = r_lw;
        n_lh        = r_lh;
        n_cur       = r_cur;
        n_left      = r_left;
        n_part      = r_part;
        n_bip       = r_bip;
        n_failed    = r_failed;
        n_stage     = r_stage;
        n_shape_bad = r_shape_bad;
        emit        = 1'b0;
        e_kind      = RK_PIXEL;
        e_red       = 8'd0;
        e_green     = 8'd0;
        e_blue      = 8'd0;
        e_alpha     = 8'd0;
        e_code      = E_MAGIC;
        e_last      = 1'b0;
        need        = '0;

        if (i_cmd.accept) begin
            if (!r_failed && r_stage == ST_HEADER) begin
                if (r_pos == '0 && r_len < 27'd4) begin
                    emit   = 1'b1;
                    e_kind = RK_ERROR;
                    e_code = E_TRUNCATED;
                end else begin
                    n_shift = sh_new;
                    if (hdr_err) begin
                        emit   = 1'b1;
                        e_kind = RK_ERROR;
                        e_code = hdr_code;
                    end else begin
                        // Capture the fields that a good check leaves behind.
                        case (r_pos)
                            POS_FORMAT: begin
                                if (sh_new == FMT_RGB565) begin
                                    n_fmt = PF_RGB565;
                                end else if (sh_new == FMT_RGBA4444) begin
                                    n_fmt = PF_RGBA4444;
                                end else begin
                                    n_fmt = PF_RGB888;
                                end
                            end
                            POS_DIMS: begin
                                n_bh = DW'(lo);
                                n_bw = DW'(hi);
                            end
                            POS_DEPTH, POS_SURF: begin
                                if (hi != 32'd1) begin
                                    n_shape_bad = 1'b1;
                                end
                            end
                            POS_MIPS: begin
                                n_lc = hi[LVL_W-1:0];
                            end
                            POS_META: begin
                                n_stage = ST_PAYLOAD;
                                n_lw    = r_bw;
                                n_lh    = r_bh;
                                n_cur   = '0;
                                n_left  = r_base_pix;
                                n_part  = '0;
                                n_bip   = '0;
                            end
                            default: begin
                                n_stage = r_stage;
                            end
                        endcase
                        if (r_pos != POS_META && rsz != '0
                                && p1 + rsz > {1'b0, r_len}) begin
                            emit   = 1'b1;
                            e_kind = RK_ERROR;
                            e_code = E_TRUNCATED;
                        end
                    end
                end
            end else if (!r_failed && r_stage == ST_PAYLOAD) begin
                if (r_fmt == PF_RGB888) begin
                    need = 28'd1;
                end else if (r_bip == 2'd0) begin
                    need = 28'd2;
                end
                if (need != '0 && {1'b0, r_pos} + need > {1'b0, r_len}) begin
                    emit   = 1'b1;
                    e_kind = RK_ERROR;
                    e_code = E_TRUNCATED;
                end else if (r_fmt == PF_RGB888 && r_bip < 2'd2) begin
                    // Gather red and green of a three-byte pixel.
                    if (r_bip == 2'd0) begin
                        n_part = {r_part[15:8], i_data_byte};
                    end else begin
                        n_part = {i_data_byte, r_part[7:0]};
                    end
                    n_bip = r_bip + 2'd1;
                end else if (r_fmt != PF_RGB888 && r_bip == 2'd0) begin
                    n_part = {8'd0, i_data_byte};
                    n_bip  = 2'd1;
                end else begin
                    // Pixel complete.
                    emit = 1'b1;
                    if (r_fmt == PF_RGB888) begin
                        e_red   = r_part[7:0];
                        e_green = r_part[15:8];
                        e_blue  = i_data_byte;
                        e_alpha = 8'hFF;
                    end else if (r_fmt == PF_RGB565) begin
                        e_red   = exp5(v[15:11]);
                        e_green = exp6(v[10:5]);
                        e_blue  = exp5(v[4:0]);
                        e_alpha = 8'hFF;
                    end else begin
                        e_red   = exp4(v[15:12]);
                        e_green = exp4(v[11:8]);
                        e_blue  = exp4(v[7:4]);
                        e_alpha = exp4(v[3:0]);
                    end
                    n_part = '0;
                    n_bip  = '0;
                    if (r_left > PW'(1)) begin
                        n_left = r_left - PW'(1);
                    end else begin
                        n_left = '0;
                        n_cur  = r_cur + LVL_W'(1);
                        if (r_cur + LVL_W'(1) >= r_lc) begin
                            n_stage = ST_DONE;
                            e_last  = 1'b1;
                        end else begin
                            n_lw   = half_dim(r_lw);
                            n_lh   = half_dim(r_lh);
                            n_left = r_next_pix;
                        end
                    end
                end
            end

            if (emit && e_kind == RK_ERROR) begin
                n_failed = 1'b1;
                e_last   = 1'b1;
            end

            // End of file: all per-file state returns to its start.
            n_pos = r_pos + POS_W'(1);
            if (p1 >= {1'b0, r_len}) begin
                n_pos       = '0;
                n_shift     = '0;
                n_fmt       = PF_RGB565;
                n_bw        = '0;
                n_bh        = '0;
                n_lc        = '0;
                n_lw        = '0;
                n_lh        = '0;
                n_cur       = '0;
                n_left      = '0;
                n_part      = '0;
                n_bip       = '0;
                n_failed    = 1'b0;
                n_stage     = ST_HEADER;
                n_shape_bad = 1'b0;
            end
        end
    end

    // File state registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_shift     <= '0;
            r_fmt       <= PF_RGB565;
            r_bw        <= '0;
            r_bh        <= '0;
            r_lc        <= '0;
            r_lw        <= '0;
            r_lh        <= '0;
            r_cur       <= '0;
            r_left      <= '0;
            r_part      <= '0;
            r_bip       <= '0;
            r_failed    <= 1'b0;
            r_stage     <= ST_HEADER;
            r_shape_bad <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_fmt       <= n_fmt;
            r_bw        <= n_bw;
            r_bh        <= n_bh;
            r_lc        <= n_lc;
            r_lw        <= n_lw;
            r_lh        <= n_lh;
            r_cur       <= n_cur;
            r_left      <= n_left;
            r_part      <= n_part;
            r_bip       <= n_bip;
            r_failed    <= n_failed;
            r_stage     <= n_stage;
            r_shape_bad <= n_shape_bad;
        end
    end

    // Pixel counts for the base level and the next smaller level.
    always_ff @(posedge i_clk) begin
        r_base_pix <= r_bw * r_bh;
        r_next_pix <= half_dim(r_lw) * half_dim(r_lh);
    end

    // Level sum: one level product per cycle, added to the sum in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx <= '0;
            r_pv   <= 1'b0;
            r_acc  <= '0;
        end else if (i_cmd.sum_start) begin
            r_sw   <= r_bw;
            r_sh   <= r_bh;
            r_sidx <= '0;
            r_pv   <= 1'b0;
            r_acc  <= '0;
        end else if (i_cmd.sum_step) begin
            if (r_pv) begin
                r_acc <= r_acc + SW'(r_prod);
            end
            if (r_sidx < r_lc) begin
                r_prod <= r_sw * r_sh;
                r_sw   <= half_dim(r_sw);
                r_sh   <= half_dim(r_sh);
                r_sidx <= r_sidx + LVL_W'(1);
                r_pv   <= 1'b1;
            end else begin
                r_pv <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind  <= e_kind;
            r_red   <= e_red;
            r_green <= e_green;
            r_blue  <= e_blue;
            r_alpha <= e_alpha;
            r_mip   <= (e_kind == RK_ERROR) ? '0 : r_cur;
            r_code  <= e_code;
            r_last  <= e_last;
        end
    end

    assign o_status.out_blocked = r_out_valid && i_stall;
    assign o_status.sum_req     = sum_req;
    assign o_status.sum_done    = (r_sidx == r_lc) && !r_pv;

    assign o_file_length = r_len;
    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha;
    assign o_mip_level   = r_mip;
    assign o_error_code  = r_code;
    assign o_last        = r_last;

    // An error result always closes the file.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == RK_ERROR |-> o_last)
        else $error("error word without last");

    // Pixel decoding only runs with a valid level count.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == ST_PAYLOAD |-> r_lc != '0 && r_cur < r_lc)
        else $error("mip level out of range during payload");

    // A word is never accepted while an unread result would be overwritten.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !emit)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/core/pvr_texture_stream_decoder_top.sv =====
// Output: a result word is registered and valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output is not stalled; after the
// mip-count field the input stalls while the level sum unit's own multiplier
// sums the pixel counts of all mip levels.
// Reset: synchronous, active low; clears file_length and all per-file state.
`default_nettype none

module pvr_texture_stream_decoder_top
    import pvrtsd_pkg::*;
#(
    parameter int MAX_DIMENSION     = MAX_DIMENSION_DEF,
    parameter int MAX_DECODED_BYTES = MAX_DECODED_BYTES_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [1:0]        paddr,
    input  wire [31:0]       pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire              i_valid,
    output logic             o_stall,
    input  wire [7:0]        i_data_byte,
    output logic             o_valid,
    input  wire              i_stall,
    output logic             o_result_kind,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [LVL_W-1:0] o_mip_level,
    output logic [3:0]       o_error_code,
    output logic             o_last
);

    t_cmd             cmd;
    t_status          status;
    logic             cfg_we;
    logic [POS_W-1:0] file_length;

    // Register port: file_length is the only register.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == REG_FILE_LENGTH);
    assign prdata = {{(32 - POS_W){1'b0}}, file_length};

    pvrtsd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pvrtsd_dp #(
        .MAX_DIMENSION     (MAX_DIMENSION),
        .MAX_DECODED_BYTES (MAX_DECODED_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (pwdata[POS_W-1:0]),
        .o_file_length (file_length),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_mip_level   (o_mip_level),
        .o_error_code  (o_error_code),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/pvr_texture_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module pvr_texture_stream_decoder_top_tb;
    import pvrtsd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_BYTES = 1750;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] level;
        logic [3:0] code;
        logic       last;
    } t_pixel_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_alpha;
    logic [3:0]  o_mip_level;
    logic [3:0]  o_error_code;
    logic        o_last;

    pvr_texture_stream_decoder_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall), .i_data_byte(i_data_byte),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_kind(o_result_kind),
        .o_red(o_red), .o_green(o_green), .o_blue(o_blue), .o_alpha(o_alpha),
        .o_mip_level(o_mip_level), .o_error_code(o_error_code), .o_last(o_last)
    );

    // Clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Decoder shadow state.
    logic [26:0]  file_len;
    int unsigned  byte_pos;
    logic [63:0]  field_shift;
    logic [1:0]   pix_fmt;
    int unsigned  base_w, base_h, level_total, level_w, level_h, cur_level;
    int unsigned  pixels_left, byte_in_pixel;
    logic [15:0]  partial;
    bit           file_failed, shape_bad;
    t_stage       stage;

    t_pixel_word  expected_words[$];
    logic [7:0]   pending_bytes[$];
    bit           byte_taken = 1'b0;
    bit           calm = 1'b0;
    int           in_gap = 0;
    int           out_hold = 0;
    int           cycles = 0;
    int           mismatches = 0;
    int           bytes_fed = 0;
    int           files_fed = 0;
    int           words_seen = 0;
    logic [31:0]  hdr[13];

    function automatic void restart_file();
        byte_pos = 0;
        field_shift = '0;
        pix_fmt = PF_RGB565;
        base_w = 0;
        base_h = 0;
        level_total = 0;
        level_w = 0;
        level_h = 0;
        cur_level = 0;
        pixels_left = 0;
        partial = '0;
        byte_in_pixel = 0;
        file_failed = 1'b0;
        stage = ST_HEADER;
        shape_bad = 1'b0;
    endfunction

    function automatic int unsigned expand(int unsigned v, int unsigned m);
        return (v * 255 + m / 2) / m;
    endfunction

    function automatic int unsigned halve(int unsigned d);
        return d > 1 ? d / 2 : 1;
    endfunction

    function automatic int unsigned level_limit(int unsigned w, int unsigned h);
        int unsigned size;
        int unsigned n;
        size = w > h ? w : h;
        n = 1;
        while (size > 1) begin
            size = size >> 1;
            n++;
        end
        return n;
    endfunction

    // Bytes in the header field that starts at pos, zero where none starts.
    function automatic int unsigned read_size(int unsigned pos);
        if (pos == 8) return 8;
        if (pos < 52 && pos % 4 == 0 && pos != 12) return 4;
        return 0;
    endfunction

    function automatic void error_word(logic [3:0] code, output t_pixel_word w);
        file_failed = 1'b1;
        w = '0;
        w.kind = RK_ERROR;
        w.code = code;
        w.last = 1'b1;
    endfunction

    // Checks the header field completed at pos; returns an error code or -1.
    function automatic int check_header(int unsigned pos);
        logic [31:0] hi;
        logic [31:0] lo;
        longint unsigned pixels;
        longint unsigned bpp;
        int unsigned w;
        int unsigned h;
        hi = field_shift[63:32];
        lo = field_shift[31:0];
        case (pos)
            3: return hi != PVR_MAGIC ? E_MAGIC : -1;
            7: return hi != 0 ? E_FLAGS : -1;
            15: begin
                if (field_shift == FMT_RGB565) pix_fmt = PF_RGB565;
                else if (field_shift == FMT_RGBA4444) pix_fmt = PF_RGBA4444;
                else if (field_shift == FMT_RGB888) pix_fmt = PF_RGB888;
                else return E_FORMAT;
                return -1;
            end
            19: return hi != 0 ? E_CSPACE : -1;
            23: return hi != 0 ? E_CHANNEL : -1;
            31: begin
                if (lo == 0 || hi == 0 || lo > 8192 || hi > 8192) return E_DIMS;
                base_h = lo;
                base_w = hi;
                return -1;
            end
            35, 39: begin
                if (hi != 1) shape_bad = 1'b1;
                return -1;
            end
            43: return (hi != 1 || shape_bad) ? E_NOT2D : -1;
            47: begin
                if (hi == 0 || hi > level_limit(base_w, base_h)) return E_MIPS;
                level_total = hi;
                return -1;
            end
            51: begin
                if (hi != 0) return E_META;
                pixels = 0;
                w = base_w;
                h = base_h;
                for (int l = 0; l < level_total; l++) begin
                    pixels += longint'(w) * h;
                    w = halve(w);
                    h = halve(h);
                end
                bpp = pix_fmt == PF_RGB888 ? 3 : 2;
                if (pixels * 4 > 64'd134217728) return E_BUDGET;
                if (pixels * bpp + 52 != longint'(file_len)) return E_SIZE;
                stage = ST_PAYLOAD;
                level_w = base_w;
                level_h = base_h;
                cur_level = 0;
                pixels_left = base_w * base_h;
                partial = '0;
                byte_in_pixel = 0;
                return -1;
            end
            default: return -1;
        endcase
    endfunction

    // Payload byte; returns 1 when a pixel or error word results.
    function automatic bit payload_byte(logic [7:0] b, int unsigned pos,
                                        output t_pixel_word w);
        int unsigned need;
        logic [15:0] v;
        w = '0;
        need = pix_fmt == PF_RGB888 ? 1 : (byte_in_pixel == 0 ? 2 : 0);
        if (need != 0 && longint'(pos) + need > longint'(file_len)) begin
            error_word(E_TRUNCATED, w);
            return 1'b1;
        end
        if (pix_fmt == PF_RGB888) begin
            if (byte_in_pixel < 2) begin
                partial = partial | (16'(b) << (8 * byte_in_pixel));
                byte_in_pixel++;
                return 1'b0;
            end
            w.red = partial[7:0];
            w.green = partial[15:8];
            w.blue = b;
            w.alpha = 8'd255;
        end else begin
            if (byte_in_pixel == 0) begin
                partial = {8'h00, b};
                byte_in_pixel = 1;
                return 1'b0;
            end
            v = {b, partial[7:0]};
            if (pix_fmt == PF_RGB565) begin
                w.red = 8'(expand(v[15:11], 31));
                w.green = 8'(expand(v[10:5], 63));
                w.blue = 8'(expand(v[4:0], 31));
                w.alpha = 8'd255;
            end else begin
                w.red = 8'(expand(v[15:12], 15));
                w.green = 8'(expand(v[11:8], 15));
                w.blue = 8'(expand(v[7:4], 15));
                w.alpha = 8'(expand(v[3:0], 15));
            end
        end
        partial = '0;
        byte_in_pixel = 0;
        w.kind = RK_PIXEL;
        w.level = 4'(cur_level);
        if (pixels_left > 0) pixels_left--;
        if (pixels_left == 0) begin
            cur_level++;
            if (cur_level >= level_total) begin
                stage = ST_DONE;
                w.last = 1'b1;
            end else begin
                level_w = halve(level_w);
                level_h = halve(level_h);
                pixels_left = level_w * level_h;
            end
        end
        return 1'b1;
    endfunction

    // Advances the shadow decoder by one file byte.
    function automatic bit decode_byte(logic [7:0] b, output t_pixel_word w);
        int unsigned pos;
        int code;
        int unsigned sz;
        bit got;
        pos = byte_pos;
        got = 1'b0;
        w = '0;
        if (!file_failed && stage == ST_HEADER) begin
            if (pos == 0 && file_len < 4) begin
                error_word(E_TRUNCATED, w);
                got = 1'b1;
            end else begin
                field_shift = {b, field_shift[63:8]};
                code = check_header(pos);
                if (code >= 0) begin
                    error_word(4'(code), w);
                    got = 1'b1;
                end else if (stage == ST_HEADER) begin
                    sz = read_size(pos + 1);
                    if (sz != 0 && longint'(pos) + 1 + sz > longint'(file_len)) begin
                        error_word(E_TRUNCATED, w);
                        got = 1'b1;
                    end
                end
            end
        end else if (!file_failed && stage == ST_PAYLOAD) begin
            got = payload_byte(b, pos, w);
        end
        byte_pos = pos + 1;
        if (byte_pos >= file_len) restart_file();
        return got;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            mismatches++;
        end
    endfunction

    // Monitor: output words are checked before the new byte is predicted.
    always @(posedge i_clk) begin
        t_pixel_word w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("pvr_texture_stream_decoder_top regression: fail");
            $finish;
        end
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                words_seen++;
                out_hold = $urandom_range(0, 13);
                if (calm) out_hold = 0;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    mismatches++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("result_kind", w.kind, o_result_kind);
                    check_field("red", w.red, o_red);
                    check_field("green", w.green, o_green);
                    check_field("blue", w.blue, o_blue);
                    check_field("alpha", w.alpha, o_alpha);
                    check_field("mip_level", w.level, o_mip_level);
                    check_field("error_code", w.code, o_error_code);
                    check_field("last", w.last, o_last);
                end
            end
            if (i_valid && !o_stall) begin
                if (decode_byte(i_data_byte, w)) begin
                    expected_words.insert(expected_words.size(), w);
                end
                byte_taken = 1'b1;
            end
        end
    end

    // Driver: one byte word at a time from the pending queue.
    always @(negedge i_clk) begin
        if (byte_taken || !i_valid) begin
            if (in_gap > 0) begin
                i_valid <= 1'b0;
                in_gap--;
            end else if (pending_bytes.size() > 0) begin
                i_data_byte <= pending_bytes.pop_front();
                i_valid <= 1'b1;
                in_gap = draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
        byte_taken = 1'b0;
        i_stall <= out_hold > 0;
        if (out_hold > 0) out_hold--;
    end

    task automatic reg_write(input logic [26:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_FILE_LENGTH;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        file_len = value;
    endtask

    // Waits until every byte is taken and every word has arrived.
    task automatic drain();
        while (pending_bytes.size() > 0 || i_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic feed(input logic [7:0] b);
        pending_bytes.insert(pending_bytes.size(), b);
        bytes_fed++;
    endtask

    task automatic feed_random(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            feed(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom));
        end
    endtask

    task automatic feed_header(input int n);
        for (int i = 0; i < n; i++) feed(8'(hdr[i / 4] >> (8 * (i % 4))));
    endtask

    // Starts a phase at the top of a file with a new file length.
    task automatic start_phase(input logic [26:0] len);
        drain();
        if (byte_pos != 0) begin
            reg_write(27'd1);
            feed(8'($urandom));
            drain();
        end
        reg_write(len);
    endtask

    task automatic good_header(input logic [1:0] fmt, input int unsigned w,
                               input int unsigned h, input int unsigned lv);
        logic [63:0] code;
        code = fmt == PF_RGB565 ? FMT_RGB565 : fmt == PF_RGBA4444 ? FMT_RGBA4444 : FMT_RGB888;
        hdr[0] = PVR_MAGIC;
        hdr[1] = 0;
        hdr[2] = code[31:0];
        hdr[3] = code[63:32];
        hdr[4] = 0;
        hdr[5] = 0;
        hdr[6] = h;
        hdr[7] = w;
        hdr[8] = 1;
        hdr[9] = 1;
        hdr[10] = 1;
        hdr[11] = lv;
        hdr[12] = 0;
    endtask

    function automatic int unsigned file_bytes(logic [1:0] fmt, int unsigned w,
                                               int unsigned h, int unsigned lv);
        int unsigned total;
        total = 0;
        for (int l = 0; l < lv; l++) begin
            total += w * h;
            w = halve(w);
            h = halve(h);
        end
        return 52 + total * (fmt == PF_RGB888 ? 3 : 2);
    endfunction

    // One 60-byte file with a single header word replaced.
    task automatic bad_small_file(input int idx, input logic [31:0] value);
        good_header(PF_RGB565, 2, 2, 1);
        hdr[idx] = value;
        feed_header(52);
        feed_random(8);
        files_fed++;
    endtask

    initial begin
        logic [1:0] fmt;
        int unsigned w, h, lv, len;
        int kind, spot;
        file_len = '0;
        restart_file();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty and too short for the magic.
        start_phase(27'd0);
        feed_random(3);
        start_phase(27'd3);
        feed_random(3);
        // Header cut off before the next field.
        start_phase(27'd20);
        good_header(PF_RGB565, 2, 2, 1);
        feed_header(20);

        // Each header check failing in turn, in a 2x2 RGB565 file.
        start_phase(27'd60);
        bad_small_file(0, 32'h0352_5651);
        bad_small_file(1, 32'h8000_0000);
        bad_small_file(2, 32'h0062_6773);
        bad_small_file(4, 32'd1);
        bad_small_file(5, 32'd1);
        bad_small_file(6, 32'd0);
        bad_small_file(7, 32'd8193);
        bad_small_file(8, 32'd2);
        bad_small_file(9, 32'd2);
        bad_small_file(10, 32'd0);
        bad_small_file(11, 32'd0);
        bad_small_file(11, 32'd3);
        bad_small_file(12, 32'd4);
        good_header(PF_RGB565, 8192, 8192, 1);
        feed_header(52);
        feed_random(8);
        good_header(PF_RGB888, 2, 2, 1);
        feed_header(52);
        feed_random(8);
        good_header(PF_RGB565, 2, 2, 1);
        feed_header(52);
        feed({8'h00, 8'h00, 8'hFF, 8'hFF, 8'h1F, 8'hF8, 8'hE0, 8'h07});

        // A length far beyond the file: the size check fails and the rest is swallowed.
        start_phase(27'd67108864);
        good_header(PF_RGBA4444, 2, 2, 2);
        feed_header(52);
        feed_random(6);

        // Length shortened mid-payload: a pixel read runs past the end.
        start_phase(27'd60);
        good_header(PF_RGBA4444, 2, 2, 1);
        feed_header(52);
        feed_random(3);
        drain();
        reg_write(27'd57);
        feed_random(2);
        // Length shortened below the position: the next pixel read reports truncation and the file ends.
        start_phase(27'd60);
        good_header(PF_RGB565, 2, 2, 1);
        feed_header(52);
        feed_random(2);
        drain();
        reg_write(27'd50);
        feed_random(1);

        // Random files, mostly well formed.
        while (bytes_fed < RANDOM_BYTES) begin
            calm = $urandom_range(0, 4) == 0;
            fmt = 2'($urandom_range(0, 2));
            w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6);
            h = $urandom_range(0, 9) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 6);
            lv = $urandom_range(1, level_limit(w, h));
            len = file_bytes(fmt, w, h, lv);
            start_phase(27'(len));
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                kind = $urandom_range(0, 9);
                files_fed++;
                if (kind == 9) begin
                    feed_random(len);
                end else begin
                    good_header(fmt, w, h, lv);
                    if (kind >= 7) begin
                        spot = $urandom_range(0, 51);
                        hdr[spot / 4] = hdr[spot / 4] ^ (32'd1 << (8 * (spot % 4) +
                                        $urandom_range(0, 7)));
                    end
                    feed_header(52);
                    feed_random(len - 52);
                end
            end
        end
        calm = 1'b0;
        drain();
        repeat (20) @(posedge i_clk);

        $display("Fed %0d bytes in %0d files; checked %0d result words, %0d mismatches.",
                 bytes_fed, files_fed, words_seen, mismatches);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("pvr_texture_stream_decoder_top regression: pass");
        end else begin
            $display("pvr_texture_stream_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== pvr_texture_stream_decoder_top.f =====
rtl/core/pvrtsd_pkg.sv
rtl/core/pvrtsd_ctrl.sv
rtl/core/pvrtsd_dp.sv
rtl/core/pvr_texture_stream_decoder_top.sv
tb/pvr_texture_stream_decoder_top_tb.sv
